@@ hdl/idtp_pkg.sv @@
// ----------------------------------------------------------------------------
// idtp_pkg
// Shared types, widths and constants of the date text parser.
// ----------------------------------------------------------------------------
package idtp_pkg;

    localparam int CH_W     = 8;
    localparam int STATUS_W = 2;
    localparam int YEAR_W   = 15;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int DIGIT_W  = 4;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_DIGITS_DEF = 100;

    localparam int QUEUE_DEPTH = 2;
    localparam int YEAR_LIMIT  = 9999;
    localparam int MONTHS      = 12;

    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_MATCH = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        TK_DIGIT,
        TK_SEP,
        TK_PLUS,
        TK_MINUS,
        TK_OTHER,
        TK_END
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [DIGIT_W-1:0] digit;
    } t_token;

    // Length of a common-year month; zero for codes that are not a month.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

@@ hdl/idtp_if.sv @@
// ----------------------------------------------------------------------------
// idtp_in_if / idtp_out_if
// Valid/ready channels for characters in and parse results out.
// ----------------------------------------------------------------------------
interface idtp_in_if;
    logic                          valid;
    logic                          ready;
    logic [idtp_pkg::CH_W-1:0]     ch;
    logic                          end_of_text;

    modport source (output valid, ch, end_of_text, input ready);
    modport sink   (input valid, ch, end_of_text, output ready);
endinterface

interface idtp_out_if;
    logic                                valid;
    logic                                ready;
    logic [idtp_pkg::STATUS_W-1:0]       status;
    logic signed [idtp_pkg::YEAR_W-1:0]  year;
    logic [idtp_pkg::MONTH_W-1:0]        month;
    logic [idtp_pkg::DAY_W-1:0]          day;

    modport source (output valid, status, year, month, day, input ready);
    modport sink   (input valid, status, year, month, day, output ready);
endinterface

@@ hdl/idtp_front.sv @@
// ----------------------------------------------------------------------------
// idtp_front
// Accepts character beats, classifies them into tokens and queues them.
// ----------------------------------------------------------------------------
module idtp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    idtp_in_if.sink          i_in,
    output logic             o_tok_valid,
    output idtp_pkg::t_token o_tok,
    input  logic             i_tok_pop
);

    localparam int PTR_W = $clog2(idtp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(idtp_pkg::QUEUE_DEPTH + 1);

    idtp_pkg::t_token r_mem [idtp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    idtp_pkg::t_token tok_in;
    logic             push;

    always_comb begin
        tok_in.digit = i_in.ch[idtp_pkg::DIGIT_W-1:0];
        if (i_in.end_of_text) begin
            tok_in.kind = idtp_pkg::TK_END;
        end else if (i_in.ch >= idtp_pkg::CH_ZERO && i_in.ch <= idtp_pkg::CH_NINE) begin
            tok_in.kind = idtp_pkg::TK_DIGIT;
        end else if (i_in.ch == idtp_pkg::CH_PLUS) begin
            tok_in.kind = idtp_pkg::TK_PLUS;
        end else if (i_in.ch == idtp_pkg::CH_MINUS) begin
            tok_in.kind = idtp_pkg::TK_MINUS;
        end else if (i_in.ch == idtp_pkg::CH_SLASH) begin
            tok_in.kind = idtp_pkg::TK_SEP;
        end else begin
            tok_in.kind = idtp_pkg::TK_OTHER;
        end
    end

    assign i_in.ready  = (r_count != CNT_W'(idtp_pkg::QUEUE_DEPTH));
    assign push        = i_in.valid && i_in.ready;
    assign o_tok_valid = (r_count != '0);
    assign o_tok       = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push && !i_tok_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!push && i_tok_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_tok_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= tok_in;
        end
    end

endmodule

@@ hdl/idtp_back.sv @@
// ----------------------------------------------------------------------------
// idtp_back
// Runs the date syntax machine on queued tokens, accumulates the fields and
// judges the text at the end marker into a registered result.
// ----------------------------------------------------------------------------
module idtp_back #(
    parameter int VALUE_BITS = idtp_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = idtp_pkg::MAX_DIGITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tok_valid,
    input  idtp_pkg::t_token i_tok,
    output logic             o_tok_pop,
    idtp_out_if.source       o_res
);

    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int PROD_W = VALUE_BITS + 4;

    typedef enum logic [2:0] {
        P_START, P_SIGNED, P_YEAR, P_EXP_MON, P_MON, P_EXP_DAY, P_DAY
    } t_phase;

    typedef enum logic [1:0] {
        F_YEAR  = 2'd0,
        F_MONTH = 2'd1,
        F_DAY   = 2'd2
    } t_field;

    t_phase                  r_phase,   n_phase;
    logic                    r_neg,     n_neg;
    logic [VALUE_BITS-1:0]   r_year,    n_year;
    logic [VALUE_BITS-1:0]   r_mon,     n_mon;
    logic [VALUE_BITS-1:0]   r_day,     n_day;
    logic [2:0]              r_ovf,     n_ovf;
    logic [CNT_W-1:0]        r_cnt,     n_cnt;
    logic                    r_failed,  n_failed;
    logic [3:0][3:0]         r_ybcd,    n_ybcd;
    logic                    r_out_valid, n_out_valid;
    idtp_pkg::t_status       r_status,  n_status;
    logic [idtp_pkg::YEAR_W-1:0]  r_oyear, n_oyear;
    logic [idtp_pkg::MONTH_W-1:0] r_omon,  n_omon;
    logic [idtp_pkg::DAY_W-1:0]   r_oday,  n_oday;

    logic                    dig_take;
    logic                    dig_first;
    t_field                  dig_field;
    logic [VALUE_BITS-1:0]   acc_sel;
    logic [PROD_W-1:0]       prod;
    logic [CNT_W-1:0]        cnt_base;

    idtp_pkg::t_status       j_status;
    logic                    div4, cent, div400, leap;
    logic [idtp_pkg::DAY_W-1:0] day_limit;
    logic                    year_sig_bad;
    logic [idtp_pkg::YEAR_W-1:0] year_out;

    // Leap rule from the last four decimal digits of the year; valid whenever
    // the year is within the four-digit range that the judge lets through.
    assign div4   = (2'({r_ybcd[1][0], 1'b0}) + r_ybcd[0][1:0]) == 2'd0;
    assign cent   = (r_ybcd[1] == 4'd0) && (r_ybcd[0] == 4'd0);
    assign div400 = cent && ((2'({r_ybcd[3][0], 1'b0}) + r_ybcd[2][1:0]) == 2'd0);
    assign leap   = (r_mon == VALUE_BITS'(2)) && ((div4 && !cent) || div400);

    assign day_limit = idtp_pkg::month_days(r_mon[idtp_pkg::MONTH_W-1:0])
                       + idtp_pkg::DAY_W'(leap);

    assign year_sig_bad = r_neg ? (r_year[VALUE_BITS-1] && (|r_year[VALUE_BITS-2:0]))
                                : r_year[VALUE_BITS-1];

    always_comb begin
        if (r_failed || r_phase != P_DAY || r_ovf != 3'b000 || year_sig_bad) begin
            j_status = idtp_pkg::ST_NO_MATCH;
        end else if (r_year == '0 || r_year > VALUE_BITS'(idtp_pkg::YEAR_LIMIT)
                     || r_mon == '0 || r_mon > VALUE_BITS'(idtp_pkg::MONTHS)
                     || r_day == '0 || r_day > VALUE_BITS'(day_limit)) begin
            j_status = idtp_pkg::ST_RANGE;
        end else begin
            j_status = idtp_pkg::ST_OK;
        end
    end

    assign year_out = r_neg ? (idtp_pkg::YEAR_W'(0) - r_year[idtp_pkg::YEAR_W-1:0])
                            : r_year[idtp_pkg::YEAR_W-1:0];

    // An end marker waits only for room in the output register.
    assign o_tok_pop = i_tok_valid
                       && (i_tok.kind != idtp_pkg::TK_END || !r_out_valid || o_res.ready);

    always_comb begin
        unique case (dig_field)
            F_MONTH: acc_sel = r_mon;
            F_DAY:   acc_sel = r_day;
            default: acc_sel = r_year;
        endcase
    end

    assign prod = (PROD_W'(acc_sel) << 3) + (PROD_W'(acc_sel) << 1)
                  + PROD_W'(i_tok.digit);
    assign cnt_base = dig_first ? '0 : r_cnt;

    always_comb begin
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_year      = r_year;
        n_mon       = r_mon;
        n_day       = r_day;
        n_ovf       = r_ovf;
        n_cnt       = r_cnt;
        n_failed    = r_failed;
        n_ybcd      = r_ybcd;
        n_out_valid = r_out_valid && !o_res.ready;
        n_status    = r_status;
        n_oyear     = r_oyear;
        n_omon      = r_omon;
        n_oday      = r_oday;
        dig_take    = 1'b0;
        dig_first   = 1'b0;
        dig_field   = F_YEAR;

        if (o_tok_pop && i_tok.kind == idtp_pkg::TK_END) begin
            n_out_valid = 1'b1;
            n_status    = j_status;
            if (j_status == idtp_pkg::ST_OK) begin
                n_oyear = year_out;
                n_omon  = r_mon[idtp_pkg::MONTH_W-1:0];
                n_oday  = r_day[idtp_pkg::DAY_W-1:0];
            end else begin
                n_oyear = '0;
                n_omon  = '0;
                n_oday  = '0;
            end
            n_phase  = P_START;
            n_neg    = 1'b0;
            n_year   = '0;
            n_mon    = '0;
            n_day    = '0;
            n_ovf    = '0;
            n_cnt    = '0;
            n_failed = 1'b0;
            n_ybcd   = '0;
        end else if (o_tok_pop && !r_failed) begin
            unique case (r_phase)
                P_START: begin
                    if (i_tok.kind == idtp_pkg::TK_PLUS || i_tok.kind == idtp_pkg::TK_MINUS) begin
                        n_neg   = (i_tok.kind == idtp_pkg::TK_MINUS);
                        n_phase = P_SIGNED;
                    end else if (i_tok.kind == idtp_pkg::TK_DIGIT) begin
                        dig_take  = 1'b1;
                        dig_first = 1'b1;
                        n_phase   = P_YEAR;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                P_SIGNED, P_EXP_MON, P_EXP_DAY: begin
                    if (i_tok.kind == idtp_pkg::TK_DIGIT) begin
                        dig_take  = 1'b1;
                        dig_first = 1'b1;
                        dig_field = (r_phase == P_SIGNED)  ? F_YEAR :
                                    (r_phase == P_EXP_MON) ? F_MONTH : F_DAY;
                        n_phase   = (r_phase == P_SIGNED)  ? P_YEAR :
                                    (r_phase == P_EXP_MON) ? P_MON : P_DAY;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                P_YEAR, P_MON: begin
                    dig_field = (r_phase == P_YEAR) ? F_YEAR : F_MONTH;
                    if (i_tok.kind == idtp_pkg::TK_DIGIT) begin
                        dig_take = 1'b1;
                    end else if (i_tok.kind == idtp_pkg::TK_SEP
                                 || i_tok.kind == idtp_pkg::TK_MINUS) begin
                        n_phase = (r_phase == P_YEAR) ? P_EXP_MON : P_EXP_DAY;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                P_DAY: begin
                    dig_field = F_DAY;
                    if (i_tok.kind == idtp_pkg::TK_DIGIT) begin
                        dig_take = 1'b1;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                default: begin
                    n_failed = 1'b1;
                end
            endcase

            if (dig_take) begin
                if (cnt_base >= CNT_W'(MAX_DIGITS)) begin
                    n_failed = 1'b1;
                end else begin
                    n_cnt = cnt_base + CNT_W'(1);
                    if (dig_field == F_YEAR) begin
                        n_ybcd = {r_ybcd[2:0], i_tok.digit};
                    end
                    if (!r_ovf[dig_field]) begin
                        if (|prod[PROD_W-1:VALUE_BITS]) begin
                            n_ovf[dig_field] = 1'b1;
                        end else begin
                            unique case (dig_field)
                                F_MONTH: n_mon  = prod[VALUE_BITS-1:0];
                                F_DAY:   n_day  = prod[VALUE_BITS-1:0];
                                default: n_year = prod[VALUE_BITS-1:0];
                            endcase
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= P_START;
            r_neg       <= 1'b0;
            r_year      <= '0;
            r_mon       <= '0;
            r_day       <= '0;
            r_ovf       <= '0;
            r_cnt       <= '0;
            r_failed    <= 1'b0;
            r_ybcd      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_year      <= n_year;
            r_mon       <= n_mon;
            r_day       <= n_day;
            r_ovf       <= n_ovf;
            r_cnt       <= n_cnt;
            r_failed    <= n_failed;
            r_ybcd      <= n_ybcd;
            r_out_valid <= n_out_valid;
        end
        r_status <= n_status;
        r_oyear  <= n_oyear;
        r_omon   <= n_omon;
        r_oday   <= n_oday;
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.status = r_status;
    assign o_res.year   = r_oyear;
    assign o_res.month  = r_omon;
    assign o_res.day    = r_oday;

endmodule

@@ hdl/iso8601_date_text_parser.sv @@
// ----------------------------------------------------------------------------
// iso8601_date_text_parser
// Character-stream parser for dates of the form [+|-]YYYY sep MM sep DD.
// ----------------------------------------------------------------------------
// The block takes one character beat per clock while the token queue has room,
// and returns one result beat for each end marker: ok with the signed year,
// month and day, no match, or out of range, with all fields zero unless the
// status is ok. A beat is classified and written to a two-entry token queue at
// the edge that accepts it; the back end takes one token per cycle, its
// multiply-by-ten accumulate on one field setting that pace; an end marker
// waits while the output register holds an untaken result and is then judged
// into it. The input stays ready while a result waits to be taken until the
// queue fills. After each end marker the parser is back in its reset state for
// the next text; there is no start-up sweep after reset.
module iso8601_date_text_parser #(
    parameter int VALUE_BITS = idtp_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = idtp_pkg::MAX_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    idtp_in_if.sink    i_in,
    idtp_out_if.source o_res
);

    logic             tok_valid;
    logic             tok_pop;
    idtp_pkg::t_token tok;

    idtp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_tok_valid (tok_valid),
        .o_tok       (tok),
        .i_tok_pop   (tok_pop)
    );

    idtp_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok_valid),
        .i_tok       (tok),
        .o_tok_pop   (tok_pop),
        .o_res       (o_res)
    );

endmodule

@@ hdl/idtp_checker.sv @@
// ----------------------------------------------------------------------------
// idtp_checker
// Port-level checks on the result channel of the date text parser.
// ----------------------------------------------------------------------------
module idtp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [idtp_pkg::STATUS_W-1:0]       i_status,
    input logic signed [idtp_pkg::YEAR_W-1:0]  i_year,
    input logic [idtp_pkg::MONTH_W-1:0]        i_month,
    input logic [idtp_pkg::DAY_W-1:0]          i_day
);

    // A stalled result beat must stay offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == idtp_pkg::ST_OK || i_status == idtp_pkg::ST_NO_MATCH
                         || i_status == idtp_pkg::ST_RANGE))
        else $error("undefined status code");

    // Any failed text reports zero fields.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != idtp_pkg::ST_OK |-> i_year == '0 && i_month == '0
                                                       && i_day == '0)
        else $error("fields not cleared on a failed parse");

    a_ok_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == idtp_pkg::ST_OK |->
            i_year != '0 && i_month >= 4'd1 && i_month <= 4'd12
            && i_day >= 5'd1 && i_day <= 5'd31)
        else $error("accepted date outside calendar limits");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered straight after reset");

endmodule

bind iso8601_date_text_parser idtp_checker u_idtp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_year      (o_res.year),
    .i_month     (o_res.month),
    .i_day       (o_res.day)
);
